/* rtl/rmf_pkg.sv */
// Package for the running median filter.
// Holds default sizes, the span register layout and the control/status structs.
// Used by every module of the block; depends on nothing.
package rmf_pkg;

  localparam int MAX_SPAN_DEF     = 31;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int SPAN_WIDTH       = 5;
  localparam int SPAN_RESET       = 2;

  // Commands from the controller to the datapath, at most two high at once.
  typedef struct packed {
    logic accept;      // latch the incoming word
    logic hist_rd;     // read the oldest history entry
    logic rem_init;    // start a removal pass
    logic rem_run;     // removal pass in progress
    logic push;        // write history, start an insertion pass
    logic ins_run;     // insertion pass in progress
    logic flush_set;   // set up left and right counts of the edge flush
    logic med_rd;      // read the middle entry of the sorted window
    logic out_load;    // load the output register
    logic flush_step;  // advance the flush to the next position
    logic frame_clr;   // end of frame: empty the window
  } rmf_cmd_t;

  typedef struct packed {
    logic full;        // window holds a full span on both sides
    logic rem_done;
    logic ins_done;
    logic frame_end;
    logic emit;        // the current word produces a median
    logic right_zero;
    logic left_lt_s;
    logic out_free;    // output register can take a new word
  } rmf_status_t;

endpackage

/* rtl/rmf_ctrl.sv */
// Controller of the running median filter: sequences removal, insertion,
// median read and edge flush. Depends on rmf_pkg for the command and status structs.
module rmf_ctrl import rmf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rmf_status_t status_i,
  output rmf_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_HRD   = 4'd2;
  localparam logic [3:0] S_REM   = 4'd3;
  localparam logic [3:0] S_PUSH  = 4'd4;
  localparam logic [3:0] S_INS   = 4'd5;
  localparam logic [3:0] S_FSET  = 4'd6;
  localparam logic [3:0] S_MRD   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_FHRD  = 4'd9;
  localparam logic [3:0] S_FREM  = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_START;
        end
      end
      S_START: begin
        state_d = status_i.full ? S_HRD : S_PUSH;
      end
      S_HRD: begin
        cmd_o.hist_rd  = 1'b1;
        cmd_o.rem_init = 1'b1;
        state_d        = S_REM;
      end
      S_REM: begin
        cmd_o.rem_run = 1'b1;
        if (status_i.rem_done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_INS;
      end
      S_INS: begin
        cmd_o.ins_run = 1'b1;
        if (status_i.ins_done) begin
          if (status_i.frame_end) begin
            state_d = S_FSET;
          end else if (status_i.emit) begin
            state_d = S_MRD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FSET: begin
        cmd_o.flush_set = 1'b1;
        state_d         = S_MRD;
      end
      S_MRD: begin
        cmd_o.med_rd = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (!status_i.frame_end) begin
            state_d = S_IDLE;
          end else if (status_i.right_zero) begin
            cmd_o.frame_clr = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.flush_step = 1'b1;
            state_d          = status_i.left_lt_s ? S_MRD : S_FHRD;
          end
        end
      end
      S_FHRD: begin
        cmd_o.hist_rd  = 1'b1;
        cmd_o.rem_init = 1'b1;
        state_d        = S_FREM;
      end
      S_FREM: begin
        cmd_o.rem_run = 1'b1;
        if (status_i.rem_done) begin
          state_d = S_MRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/rmf_datapath.sv */
// Datapath of the running median filter: sorted window memory, sample history
// memory, counters and the output register. Depends on rmf_pkg.
module rmf_datapath import rmf_pkg::*; #(
  parameter int MaxSpan     = MAX_SPAN_DEF,
  parameter int SampleWidth = SAMPLE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          span_we_i,
  input  logic [SPAN_WIDTH-1:0]         span_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic                          frame_end_i,
  input  rmf_cmd_t                      cmd_i,
  output rmf_status_t                   status_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic signed [SampleWidth-1:0] median_o,
  output logic                          last_out_o
);

  localparam int WinDepth  = 2 * MaxSpan + 1;
  localparam int HistDepth = 2 * MaxSpan + 2;
  localparam int AW  = $clog2(WinDepth);
  localparam int CW  = $clog2(WinDepth + 1);
  localparam int HW  = $clog2(HistDepth);
  localparam int SPW = $clog2(MaxSpan + 1);
  localparam int SSW = $clog2(MaxSpan + 2);
  localparam int SpanActReset = (SPAN_RESET > MaxSpan) ? MaxSpan : SPAN_RESET;
  localparam logic [HW:0] HistDepthW = (HW + 1)'(HistDepth);

  logic [SPAN_WIDTH-1:0]  span_q;
  logic [SPW-1:0]         span_act_q, span_clamped;
  logic [SampleWidth-1:0] x_q;
  logic                   fe_q;
  logic [CW-1:0]          count_q;
  logic [HW-1:0]          hp_q;
  logic [SSW-1:0]         seen_q;
  logic                   ge_q;
  logic [CW-1:0]          left_q, right_q, left_d;
  logic [CW-1:0]          ra_q;
  logic [AW-1:0]          tag_q;
  logic                   pend_q, found_q;
  logic                   out_valid_q, last_q;
  logic [SampleWidth-1:0] median_q;

  logic [SampleWidth-1:0] win_mem [WinDepth];
  logic [SampleWidth-1:0] hist_mem [HistDepth];
  logic [SampleWidth-1:0] win_rd_q, hist_rd_q;

  logic                   win_re, win_we;
  logic [AW-1:0]          win_raddr, win_waddr;
  logic [SampleWidth-1:0] win_wdata;
  logic [CW-1:0]          s_cw, cnt_m1, ra_m1;
  logic [HW:0]            old_sum;
  logic [HW-1:0]          old_idx;
  logic                   greater, rem_last, rem_done, ins_done, out_free;

  assign s_cw     = CW'(span_act_q);
  assign cnt_m1   = count_q - CW'(1);
  assign ra_m1    = ra_q - CW'(1);
  assign greater  = $signed(win_rd_q) > $signed(x_q);
  assign rem_last = (CW'(tag_q) == cnt_m1);
  assign rem_done = cmd_i.rem_run && pend_q && rem_last;
  assign ins_done = cmd_i.ins_run && (pend_q ? !greater : (ra_q == '0));
  assign out_free = !out_valid_q || !out_stall_i;

  // The oldest sample sits count entries behind the write pointer.
  assign old_sum = {1'b0, hp_q} + HistDepthW - (HW + 1)'(count_q);
  assign old_idx = (old_sum >= HistDepthW) ? HW'(old_sum - HistDepthW) : HW'(old_sum);

  always_comb begin
    if (int'(span_q) > MaxSpan) begin
      span_clamped = SPW'(MaxSpan);
    end else begin
      span_clamped = SPW'(span_q);
    end
  end

  always_comb begin
    if (ge_q && (count_q >= s_cw + CW'(1))) begin
      left_d = cnt_m1 - s_cw;
    end else begin
      left_d = '0;
    end
  end

  // Window memory port selection. Removal scans upward and moves each entry
  // above the removed one down by one; insertion scans downward and moves each
  // entry greater than the new sample up by one until the gap is found.
  always_comb begin
    win_re    = 1'b0;
    win_raddr = '0;
    win_we    = 1'b0;
    win_waddr = '0;
    win_wdata = x_q;
    if (cmd_i.rem_run) begin
      win_re    = (ra_q < count_q);
      win_raddr = ra_q[AW-1:0];
      if (pend_q && found_q) begin
        win_we    = 1'b1;
        win_waddr = tag_q - AW'(1);
        win_wdata = win_rd_q;
      end
    end else if (cmd_i.ins_run) begin
      win_re    = (ra_q != '0);
      win_raddr = ra_m1[AW-1:0];
      if (pend_q) begin
        win_we    = 1'b1;
        win_waddr = tag_q + AW'(1);
        win_wdata = greater ? win_rd_q : x_q;
      end else if (ra_q == '0) begin
        win_we    = 1'b1;
        win_waddr = '0;
        win_wdata = x_q;
      end
    end else if (cmd_i.med_rd) begin
      win_re    = 1'b1;
      win_raddr = AW'(count_q >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_wdata;
    end
    if (win_re) begin
      win_rd_q <= win_mem[win_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      hist_mem[hp_q] <= x_q;
    end
    if (cmd_i.hist_rd) begin
      hist_rd_q <= hist_mem[old_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_i;
    end
    if (win_re) begin
      tag_q <= win_raddr;
    end
    if (cmd_i.out_load) begin
      median_q <= win_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q      <= SPAN_WIDTH'(SPAN_RESET);
      span_act_q  <= SPW'(SpanActReset);
      fe_q        <= 1'b0;
      count_q     <= '0;
      hp_q        <= '0;
      seen_q      <= '0;
      ge_q        <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      ra_q        <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (span_we_i) begin
        span_q <= span_i;
      end
      if (cmd_i.accept) begin
        fe_q <= frame_end_i;
        if (count_q == '0 && seen_q == '0) begin
          span_act_q <= span_clamped;
        end
      end

      pend_q <= (cmd_i.rem_run || cmd_i.ins_run) && win_re;

      if (cmd_i.rem_init) begin
        ra_q <= '0;
      end else if (cmd_i.push) begin
        ra_q <= count_q;
      end else if (cmd_i.rem_run && win_re) begin
        ra_q <= ra_q + CW'(1);
      end else if (cmd_i.ins_run && win_re) begin
        ra_q <= ra_m1;
      end

      if (cmd_i.rem_init) begin
        found_q <= 1'b0;
      end else if (cmd_i.rem_run && pend_q && !found_q &&
                   ((win_rd_q == hist_rd_q) || rem_last)) begin
        found_q <= 1'b1;
      end

      if (cmd_i.frame_clr) begin
        count_q <= '0;
      end else if (rem_done) begin
        count_q <= cnt_m1;
      end else if (ins_done) begin
        count_q <= count_q + CW'(1);
      end

      if (cmd_i.frame_clr) begin
        hp_q <= '0;
      end else if (cmd_i.push) begin
        hp_q <= (hp_q == HW'(HistDepth - 1)) ? '0 : hp_q + HW'(1);
      end

      if (cmd_i.frame_clr) begin
        seen_q <= '0;
      end else if (cmd_i.push) begin
        ge_q <= (seen_q >= SSW'(span_act_q));
        if (seen_q < SSW'(span_act_q) + SSW'(1)) begin
          seen_q <= seen_q + SSW'(1);
        end
      end

      if (cmd_i.flush_set) begin
        left_q  <= left_d;
        right_q <= cnt_m1 - left_d;
      end else if (cmd_i.flush_step) begin
        right_q <= right_q - CW'(1);
        if (left_q < s_cw) begin
          left_q <= left_q + CW'(1);
        end
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        last_q      <= fe_q && (right_q == '0);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.full       = (count_q >= CW'({span_act_q, 1'b1}));
    status_o.rem_done   = rem_done;
    status_o.ins_done   = ins_done;
    status_o.frame_end  = fe_q;
    status_o.emit       = ge_q;
    status_o.right_zero = (right_q == '0);
    status_o.left_lt_s  = (left_q < s_cw);
    status_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = $signed(median_q);
  assign last_out_o  = last_q;

endmodule

/* rtl/running_median_filter_unit.sv */
// Top level of the running median filter: controller plus datapath.
// Depends on rmf_pkg, rmf_ctrl and rmf_datapath.
//
// Streams a frame of signed samples and returns, for each position, the upper
// median of the samples within span positions on either side, clipped at the
// frame edges. Results lag the input by span words; the word marked frame_end
// releases the remaining results of the right edge, at most span+1 of them, the
// last one flagged with last_out. Span is sampled at the first word of each
// frame and clamped to MaxSpan. The block works on one input word at a time:
// the window holds n = 2*span+1 entries, and once it is full each word takes
// two passes over the sorted window memory, one to take the oldest sample out
// and one to slide the new sample into place. In the edge flush each further
// result is read from the middle of the window, after a removal pass once the
// window starts shrinking. A finished result waits in the output register while
// the next word is taken in, and a new result is held back until the output
// register is free. No clearing pass is needed after reset.
module running_median_filter_unit import rmf_pkg::*; #(
  parameter int MaxSpan     = MAX_SPAN_DEF,
  parameter int SampleWidth = SAMPLE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          span_we_i,
  input  logic [SPAN_WIDTH-1:0]         span_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SampleWidth-1:0] median_o,
  output logic                          last_out_o
);

  rmf_cmd_t    cmd;
  rmf_status_t status;

  rmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rmf_datapath #(
    .MaxSpan     (MaxSpan),
    .SampleWidth (SampleWidth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .span_we_i   (span_we_i),
    .span_i      (span_i),
    .sample_i    (sample_i),
    .frame_end_i (frame_end_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .median_o    (median_o),
    .last_out_o  (last_out_o)
  );

endmodule

/* rtl/rmf_checker.sv */
// Port-level checks for the running median filter, bound to the top level.
// Depends on rmf_pkg for the default sample width.
module rmf_checker import rmf_pkg::*; #(
  parameter int SampleWidth = SAMPLE_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SampleWidth-1:0] median_o,
  input logic                          last_out_o
);

  // A stalled result word stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(median_o) && $stable(last_out_o))
    else $error("result payload changed while stalled");

  // Only one word is worked on at a time, so taking a word closes the input.
  a_in_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken before the first was finished");

  // A new result only appears while a word is being worked on.
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word appeared while the block was idle");

endmodule

bind running_median_filter_unit rmf_checker #(.SampleWidth(SampleWidth)) u_rmf_checker (.*);
